// ===== hdl/oree_pkg.sv =====
// Shared types and constants of the occupancy rate estimator.
package oree_pkg;

  localparam int DATA_W      = 64;
  localparam int DIGIT_W     = 8;
  localparam int CDIV_STEPS  = DATA_W / DIGIT_W;
  localparam int LDIV_STEPS  = DATA_W;
  localparam int CNT_W       = $clog2(LDIV_STEPS);
  localparam int NS_DIV      = 33;
  localparam int REM_W       = 6;
  localparam int RECIP       = 7944;
  localparam int RECIP_SHIFT = 18;
  localparam int EWMA_SHIFT  = 3;
  localparam int AVG_SHIFT   = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CDIV,
    ST_CHECK,
    ST_LDIV,
    ST_EWMA,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic cdiv_step;
    logic ldiv_step;
    logic ewma;
    logic out_load;
    logic upd;
    logic zdiv;
  } cmd_t;

  typedef struct packed {
    logic ns_zero;
    logic half_zero;
  } sts_t;

endpackage

// ===== hdl/occupancy_rate_ewma_estimator_unit.sv =====
// Top level of the occupancy rate estimator with exponential average.
//
//  channel  direction  payload
//  s_*      in         tdata: occupancy_count, timestamp
//  m_*      out        tdata: average_occupancy, smoothed_occupancy;
//                      tuser: updated, zero_divisor
//
// When an update happens, a sample passes through these steps in order: accept, the
// byte-wise divide by 33, a check, the one-bit-per-cycle divider, the average update,
// and the load of the result register. Without an update the divider and average are skipped.
// A new sample is taken while the previous result waits in the output register.
// Reset is synchronous and clears the stored sample pair, average and smoothed value.
module occupancy_rate_ewma_estimator_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // occupancy_count [63:0], timestamp [127:64]
  input  logic [2*oree_pkg::DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // average_occupancy [63:0], smoothed_occupancy [127:64]
  output logic [2*oree_pkg::DATA_W-1:0]     m_tdata,
  // updated [0], zero_divisor [1]
  output logic [1:0]                        m_tuser
);

  oree_pkg::cmd_t cmd;
  oree_pkg::sts_t sts;

  oree_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  oree_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .sts     (sts),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

// ===== hdl/oree_ctrl.sv =====
// Controller state machine that sequences the estimator datapath.
module oree_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  oree_pkg::sts_t  sts,
  output oree_pkg::cmd_t  cmd
);

  oree_pkg::state_t             state, state_next;
  logic [oree_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic                         upd, upd_next;
  logic                         zdiv, zdiv_next;
  logic                         out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= oree_pkg::ST_IDLE;
      cnt       <= '0;
      upd       <= 1'b0;
      zdiv      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      upd       <= upd_next;
      zdiv      <= zdiv_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    upd_next   = upd;
    zdiv_next  = zdiv;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      oree_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          upd_next   = 1'b0;
          zdiv_next  = 1'b0;
          state_next = oree_pkg::ST_CDIV;
        end
      end
      oree_pkg::ST_CDIV: begin
        cmd.cdiv_step = 1'b1;
        cnt_next      = cnt + oree_pkg::CNT_W'(1);
        if (cnt == oree_pkg::CNT_W'(oree_pkg::CDIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = oree_pkg::ST_CHECK;
        end
      end
      oree_pkg::ST_CHECK: begin
        if (sts.ns_zero) begin
          state_next = oree_pkg::ST_FINISH;
        end else if (sts.half_zero) begin
          zdiv_next  = 1'b1;
          state_next = oree_pkg::ST_FINISH;
        end else begin
          state_next = oree_pkg::ST_LDIV;
        end
      end
      oree_pkg::ST_LDIV: begin
        cmd.ldiv_step = 1'b1;
        cnt_next      = cnt + oree_pkg::CNT_W'(1);
        if (cnt == oree_pkg::CNT_W'(oree_pkg::LDIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = oree_pkg::ST_EWMA;
        end
      end
      oree_pkg::ST_EWMA: begin
        cmd.ewma   = 1'b1;
        upd_next   = 1'b1;
        state_next = oree_pkg::ST_FINISH;
      end
      oree_pkg::ST_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = oree_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = oree_pkg::ST_IDLE;
      end
    endcase
    cmd.upd  = upd;
    cmd.zdiv = zdiv;
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  assign m_tvalid = out_valid;

`ifndef NO_ASSERTIONS
  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_tready))
    else $error("result loaded over an untaken result");

  a_ewma_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == oree_pkg::ST_EWMA) |-> ($past(state) == oree_pkg::ST_LDIV))
    else $error("average update without a finished division");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(cmd.upd && cmd.zdiv))
    else $error("update and zero divisor flagged together");
`endif

endmodule

// ===== hdl/oree_dpath.sv =====
// Datapath: deltas, divide by 33, iterative divider, average update, result register.
module oree_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [2*oree_pkg::DATA_W-1:0]     s_tdata,
  input  oree_pkg::cmd_t                    cmd,
  output oree_pkg::sts_t                    sts,
  output logic [2*oree_pkg::DATA_W-1:0]     m_tdata,
  output logic [1:0]                        m_tuser
);

  localparam int W      = oree_pkg::DATA_W;
  localparam int DW     = oree_pkg::DIGIT_W;
  localparam int RW     = oree_pkg::REM_W;
  localparam int XW     = RW + DW;
  localparam int PW     = 2 * XW - 1;

  logic [W-1:0]  prev_occ, prev_ts;
  logic [W-1:0]  last_avg, smoothed;
  logic [W-1:0]  cd_acc;
  logic [RW-1:0] cd_rem;
  logic [W-1:0]  dv_quo, dv_rem;
  logic [W-1:0]  out_avg, out_smooth;
  logic          out_upd, out_zdiv;

  logic [W-1:0]  in_occ, in_ts, dts;
  logic [XW-1:0] cd_x, cd_r;
  logic [PW-1:0] cd_prod;
  logic [DW-1:0] cd_q;
  logic [W-1:0]  divisor, dv_shift, dv_diff;
  logic          dv_fit;
  logic [W-1:0]  ewma_sum;

  assign in_occ = s_tdata[W-1:0];
  assign in_ts  = s_tdata[2*W-1:W];
  assign dts    = in_ts - prev_ts;

  // One quotient byte per step: reciprocal multiply, exact for this digit range.
  assign cd_x    = {cd_rem, cd_acc[W-1 -: DW]};
  assign cd_prod = PW'(cd_x) * PW'(oree_pkg::RECIP);
  assign cd_q    = cd_prod[oree_pkg::RECIP_SHIFT +: DW];
  assign cd_r    = cd_x - XW'(cd_q) * XW'(oree_pkg::NS_DIV);

  // Restoring division of the occupancy delta by half the nanosecond delta.
  assign divisor  = {1'b0, cd_acc[W-1:1]};
  assign dv_shift = {dv_rem[W-2:0], dv_quo[W-1]};
  assign dv_fit   = (dv_shift >= divisor);
  assign dv_diff  = dv_shift - divisor;

  // Seven eighths of the old value plus the scaled average, wrapped before the shift.
  assign ewma_sum = ((smoothed << oree_pkg::EWMA_SHIFT) - smoothed)
                  + (dv_quo << oree_pkg::AVG_SHIFT);

  assign sts.ns_zero   = (cd_acc == '0);
  assign sts.half_zero = (cd_acc[W-1:1] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_occ <= '0;
      prev_ts  <= '0;
      last_avg <= '0;
      smoothed <= '0;
    end else begin
      if (cmd.load) begin
        prev_occ <= in_occ;
        prev_ts  <= in_ts;
      end
      if (cmd.ewma) begin
        last_avg <= dv_quo;
        smoothed <= ewma_sum >> oree_pkg::EWMA_SHIFT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cd_acc <= (dts << 3) + (dts << 1);
      cd_rem <= '0;
      dv_quo <= in_occ - prev_occ;
      dv_rem <= '0;
    end else begin
      if (cmd.cdiv_step) begin
        cd_acc <= {cd_acc[W-DW-1:0], cd_q};
        cd_rem <= cd_r[RW-1:0];
      end
      if (cmd.ldiv_step) begin
        dv_rem <= dv_fit ? dv_diff : dv_shift;
        dv_quo <= {dv_quo[W-2:0], dv_fit};
      end
    end
    if (cmd.out_load) begin
      out_avg    <= last_avg;
      out_smooth <= smoothed;
      out_upd    <= cmd.upd;
      out_zdiv   <= cmd.zdiv;
    end
  end

  assign m_tdata = {out_smooth, out_avg};
  assign m_tuser = {out_zdiv, out_upd};

`ifndef NO_ASSERTIONS
  a_cdiv_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.cdiv_step |-> (cd_rem < RW'(oree_pkg::NS_DIV)))
    else $error("constant divider remainder out of range");

  a_ldiv_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.ldiv_step |-> (dv_rem < divisor))
    else $error("divider remainder not below divisor");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the occupancy rate estimator: directed and random samples.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                DATA_W    = oree_pkg::DATA_W;
  localparam logic [DATA_W-1:0] NS_MUL    = 64'd10;
  localparam logic [DATA_W-1:0] NS_DIVIDE = 64'(oree_pkg::NS_DIV);
  localparam logic [DATA_W-1:0] EWMA_KEEP = 64'd7;
  localparam int                MAX_SHOWN = 10;

  typedef struct packed {
    logic [DATA_W-1:0] average;
    logic [DATA_W-1:0] smoothed;
    logic              updated;
    logic              zero_div;
  } estimate_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [2*DATA_W-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [2*DATA_W-1:0]   m_tdata;
  logic [1:0]            m_tuser;

  logic [DATA_W-1:0]     last_occ = '0;
  logic [DATA_W-1:0]     last_stamp = '0;
  logic [DATA_W-1:0]     avg_occ = '0;
  logic [DATA_W-1:0]     ewma_occ = '0;
  estimate_t             expected_estimates[$];

  int idle_limit = 15;
  int samples_sent = 0;
  int results_seen = 0;
  int updates_seen = 0;
  int zero_div_seen = 0;
  int stalled_seen = 0;
  int mismatches = 0;

  occupancy_rate_ewma_estimator_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  // Advances the stored sample pair and returns the result this sample should produce.
  function automatic estimate_t estimate_rate(input logic [DATA_W-1:0] occ,
                                              input logic [DATA_W-1:0] stamp);
    logic [DATA_W-1:0] occ_delta;
    logic [DATA_W-1:0] scaled;
    logic [DATA_W-1:0] ns_delta;
    logic [DATA_W-1:0] half_ns;
    estimate_t         e;
    occ_delta  = occ - last_occ;
    scaled     = (stamp - last_stamp) * NS_MUL;
    ns_delta   = scaled / NS_DIVIDE;
    half_ns    = ns_delta >> 1;
    last_occ   = occ;
    last_stamp = stamp;
    e.updated  = 1'b0;
    e.zero_div = 1'b0;
    if (ns_delta != '0) begin
      if (half_ns == '0) begin
        e.zero_div = 1'b1;
      end else begin
        avg_occ   = occ_delta / half_ns;
        scaled    = EWMA_KEEP * ewma_occ + (avg_occ << oree_pkg::AVG_SHIFT);
        ewma_occ  = scaled >> oree_pkg::EWMA_SHIFT;
        e.updated = 1'b1;
      end
    end
    e.average  = avg_occ;
    e.smoothed = ewma_occ;
    return e;
  endfunction

  task automatic send_sample(input logic [DATA_W-1:0] occ, input logic [DATA_W-1:0] stamp);
    int gap;
    gap = $urandom_range(idle_limit, 0);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {stamp, occ};
    do @(posedge clk); while (s_tready !== 1'b1);
    expected_estimates.push_back(estimate_rate(occ, stamp));
    samples_sent++;
  endtask

  task automatic advance(input logic [DATA_W-1:0] stamp_step, input logic [DATA_W-1:0] occ_step);
    send_sample(last_occ + occ_step, last_stamp + stamp_step);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_for_results();
    while (expected_estimates.size() != 0) @(posedge clk);
  endtask

  task automatic test_first_sample();
    idle_limit = 15;
    send_sample(64'd1000, 64'd3300);
    advance(64'd3300, 64'd5000);
  endtask

  task automatic test_skipped_updates();
    advance(64'd0, 64'd77);
    advance(64'd1, 64'd5);
    advance(64'd3, 64'd5);
    advance(64'd4, 64'd9);
    advance(64'd5, 64'd11);
    advance(64'd6, 64'd13);
    advance(64'd7, 64'd100);
  endtask

  task automatic test_extremes();
    advance(64'd7, '1);
    advance(64'h8000_0000_0000_0000, 64'd12345);
    send_sample('0, '0);
    send_sample('1, '1);
    advance('1, '0);
    send_sample(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_sample(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    advance(64'd33_000_000_000, '0);
    advance(64'd7, 64'h0123_4567_89AB_CDEF);
  endtask

  task automatic test_random_traffic(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        idle_limit = ($urandom_range(2, 0) == 0) ? 0 : 15;
      end
      r = $urandom_range(99, 0);
      if (r < 6) begin
        advance(64'($urandom_range(7, 0)), wide_random() >> $urandom_range(63, 0));
      end else if (r < 60) begin
        advance(64'($urandom_range(1 << 20, 7)), 64'($urandom_range(1 << 24, 0)));
      end else if (r < 72) begin
        advance(wide_random() >> $urandom_range(63, 24), wide_random());
      end else if (r < 85) begin
        advance(64'($urandom), wide_random() >> $urandom_range(63, 0));
      end else begin
        send_sample(wide_random(), wide_random());
      end
    end
    idle_limit = 15;
  endtask

  task automatic test_drain_pause();
    advance(64'd5000, 64'd700);
    advance(64'd4, 64'd3);
    go_quiet();
    wait_for_results();
    advance(64'd9000, 64'd1200);
    advance(64'd0, 64'd8);
  endtask

  initial begin
    estimate_t want;
    estimate_t got;
    wait (rst == 1'b0);
    forever begin
      int stall;
      stall = $urandom_range(idle_limit, 0);
      @(negedge clk);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      got.average  = m_tdata[DATA_W-1:0];
      got.smoothed = m_tdata[2*DATA_W-1:DATA_W];
      got.updated  = m_tuser[0];
      got.zero_div = m_tuser[1];
      results_seen++;
      updates_seen  += (got.updated === 1'b1);
      zero_div_seen += (got.zero_div === 1'b1);
      stalled_seen  += (got.updated === 1'b0 && got.zero_div === 1'b0);
      if (expected_estimates.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected transfer: avg=%h smooth=%h upd=%b zdiv=%b",
                   got.average, got.smoothed, got.updated, got.zero_div);
      end else begin
        want = expected_estimates.pop_front();
        if (got.average !== want.average || got.smoothed !== want.smoothed ||
            got.updated !== want.updated || got.zero_div !== want.zero_div) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("result %0d expected: avg=%h smooth=%h upd=%b zdiv=%b", results_seen,
                     want.average, want.smoothed, want.updated, want.zero_div);
            $display("result %0d actual:   avg=%h smooth=%h upd=%b zdiv=%b", results_seen,
                     got.average, got.smoothed, got.updated, got.zero_div);
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_first_sample();
    test_skipped_updates();
    test_extremes();
    test_random_traffic(200);
    test_drain_pause();
    test_random_traffic(230);
    go_quiet();
    wait_for_results();
    repeat (100) @(posedge clk);
    $display("Sent %0d samples and checked %0d results: %0d updates,", samples_sent,
             results_seen, updates_seen);
    $display("%0d halved-divisor skips and %0d skips with no elapsed time.", zero_div_seen,
             stalled_seen);
    if (mismatches == 0) begin
      $display("occupancy_rate_ewma_estimator_unit: match");
    end else begin
      $display("occupancy_rate_ewma_estimator_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", expected_estimates.size());
    $display("occupancy_rate_ewma_estimator_unit: mismatch");
    $finish;
  end

endmodule
